/* rtl/core/ifsf_pkg.sv */
// Shared types and constants of the information frame stuffing framer.
`default_nettype none
package ifsf_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned PADDR_W     = 5;
	localparam int unsigned PDATA_W     = 32;
	localparam int unsigned REG_IDX_W   = 3;

	// Register indexes, byte address is 4 * index
	localparam logic [REG_IDX_W-1:0] REG_FLAG      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FLAG_SUB  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ESC_SUB   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ADDRESS   = 3'd4;

	localparam logic [BYTE_W-1:0] FLAG_RESET     = 8'h7E;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET   = 8'h7D;
	localparam logic [BYTE_W-1:0] FLAG_SUB_RESET = 8'h5E;
	localparam logic [BYTE_W-1:0] ESC_SUB_RESET  = 8'h5D;
	localparam logic [BYTE_W-1:0] ADDRESS_RESET  = 8'h03;
	localparam logic [BYTE_W-1:0] CHECK_START    = 8'h00;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_value;
		logic [BYTE_W-1:0] escape_value;
		logic [BYTE_W-1:0] flag_substitute;
		logic [BYTE_W-1:0] escape_substitute;
		logic [BYTE_W-1:0] address_value;
	} cfg_t;

	// One classified packet byte, ready for the output sequencer
	typedef struct packed {
		logic              opens;
		logic              seq;
		logic              stuffed;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] substitute;
		logic              closes;
		logic [BYTE_W-1:0] check;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/core/ifsf_front.sv */
// Front end: accept packet bytes, track the frame, classify stuffing, fold the check.
`default_nettype none
module ifsf_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ifsf_pkg::cfg_t        cfg,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire [ifsf_pkg::BYTE_W-1:0] data_byte,
	input  wire                   first_of_frame,
	input  wire                   last_of_frame,
	input  wire                   no_stuff,
	input  wire                   sequence_bit,
	input  wire                   q_full,
	output logic                  push,
	output ifsf_pkg::cmd_t        push_cmd
);

	logic [ifsf_pkg::BYTE_W-1:0] check_q;
	logic                        inside_q;
	logic                        take;
	logic                        keep;
	logic                        is_flag;
	logic                        is_esc;
	logic [ifsf_pkg::BYTE_W-1:0] check_next;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	// Drop bytes that arrive outside a frame
	assign keep     = first_of_frame || inside_q;
	assign push     = take && keep;

	assign is_flag    = !no_stuff && (data_byte == cfg.flag_value);
	assign is_esc     = !no_stuff && (data_byte == cfg.escape_value);
	assign check_next = (first_of_frame ? ifsf_pkg::CHECK_START : check_q) ^ data_byte;

	always_comb begin
		push_cmd.opens      = first_of_frame;
		push_cmd.seq        = sequence_bit;
		push_cmd.stuffed    = is_flag || is_esc;
		push_cmd.data       = data_byte;
		push_cmd.substitute = is_flag ? cfg.flag_substitute : cfg.escape_substitute;
		push_cmd.closes     = last_of_frame;
		push_cmd.check      = check_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q  <= ifsf_pkg::CHECK_START;
			inside_q <= 1'b0;
		end else if (push) begin
			check_q  <= check_next;
			inside_q <= !last_of_frame;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/ifsf_queue.sv */
// Short command queue between the front end and the output sequencer.
`default_nettype none
module ifsf_queue #(
	parameter int unsigned Depth = ifsf_pkg::QUEUE_DEPTH
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  ifsf_pkg::cmd_t push_cmd,
	output logic           full,
	input  wire            pop,
	output logic           not_empty,
	output ifsf_pkg::cmd_t head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	ifsf_pkg::cmd_t  mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/ifsf_back.sv */
// Output sequencer: expand each command into line bytes, one per cycle while the line side is ready.
`default_nettype none
module ifsf_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ifsf_pkg::cfg_t        cfg,
	input  wire                   head_valid,
	input  ifsf_pkg::cmd_t        head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [ifsf_pkg::BYTE_W-1:0] out_byte,
	output logic                  run_last,
	output logic                  frame_end
);

	typedef enum logic [2:0] {
		PH_FLAG, PH_ADDR, PH_CTRL, PH_HCHK, PH_DATA0, PH_DATA1, PH_CHECK, PH_CLOSE
	} phase_t;

	phase_t                      phase_q;
	logic                        mid_q;
	phase_t                      cur;
	phase_t                      nxt;
	logic                        done;
	logic                        advance;
	logic                        emit;
	logic [ifsf_pkg::BYTE_W-1:0] ctrl;
	logic [ifsf_pkg::BYTE_W-1:0] byte_sel;

	assign advance = !out_valid || out_ready;
	assign emit    = advance && head_valid;
	assign ctrl    = {1'b0, head.seq, 6'b0};
	assign cur     = mid_q ? phase_q : (head.opens ? PH_FLAG : PH_DATA0);

	always_comb begin
		nxt  = PH_DATA0;
		done = 1'b0;
		unique case (cur)
			PH_FLAG:  nxt = PH_ADDR;
			PH_ADDR:  nxt = PH_CTRL;
			PH_CTRL:  nxt = PH_HCHK;
			PH_HCHK:  nxt = PH_DATA0;
			PH_DATA0: begin
				if (head.stuffed) begin
					nxt = PH_DATA1;
				end else if (head.closes) begin
					nxt = PH_CHECK;
				end else begin
					done = 1'b1;
				end
			end
			PH_DATA1: begin
				if (head.closes) begin
					nxt = PH_CHECK;
				end else begin
					done = 1'b1;
				end
			end
			PH_CHECK: nxt = PH_CLOSE;
			PH_CLOSE: done = 1'b1;
			default:  done = 1'b1;
		endcase
	end

	always_comb begin
		unique case (cur)
			PH_FLAG:  byte_sel = cfg.flag_value;
			PH_ADDR:  byte_sel = cfg.address_value;
			PH_CTRL:  byte_sel = ctrl;
			PH_HCHK:  byte_sel = cfg.address_value ^ ctrl;
			PH_DATA0: byte_sel = head.stuffed ? cfg.escape_value : head.data;
			PH_DATA1: byte_sel = head.substitute;
			PH_CHECK: byte_sel = head.check;
			PH_CLOSE: byte_sel = cfg.flag_value;
			default:  byte_sel = head.data;
		endcase
	end

	assign pop = emit && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FLAG;
			mid_q     <= 1'b0;
			out_valid <= 1'b0;
			out_byte  <= '0;
			run_last  <= 1'b0;
			frame_end <= 1'b0;
		end else if (advance) begin
			out_valid <= head_valid;
			if (head_valid) begin
				out_byte  <= byte_sel;
				run_last  <= done;
				frame_end <= (cur == PH_CLOSE);
				mid_q     <= !done;
				phase_q   <= nxt;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/info_frame_stuffing_framer.sv */
// Top level of the information frame stuffing framer with its register file.
// An accepted packet byte goes through the queue and then the output register to the line.
// One line byte per cycle while the line side is ready, set by the output sequencer; a packet
// byte gives one line byte, plus 4 on opening a frame, 1 when stuffed and 2 on closing it.
// Reset clears the frame state and the check, empties the queue and the output register,
// and loads the registers with flag 0x7E, escape 0x7D, substitutes 0x5E/0x5D, address 0x03.
`default_nettype none
module info_frame_stuffing_framer #(
	parameter int unsigned QueueDepth = ifsf_pkg::QUEUE_DEPTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// APB register port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [ifsf_pkg::PADDR_W-1:0]  paddr,
	input  wire [ifsf_pkg::PDATA_W-1:0]  pwdata,
	output logic [ifsf_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// Packet byte stream in
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire [7:0]                    s_axis_tdata,  // [7:0] data_byte
	input  wire                          s_axis_tlast,  // last_of_frame
	input  wire [2:0]                    s_axis_tuser,  // [0] first_of_frame, [1] no_stuff,
	                                                    // [2] sequence_bit
	// Line byte stream out
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [7:0]                   m_axis_tdata,  // [7:0] out_byte
	output logic                         m_axis_tlast,  // run_last
	output logic [0:0]                   m_axis_tuser   // [0] frame_end
);

	ifsf_pkg::cfg_t                       cfg_q;
	logic                                 wr_req;
	logic [ifsf_pkg::REG_IDX_W-1:0]       reg_idx;
	logic [ifsf_pkg::BYTE_W-1:0]          rd_byte;

	logic            q_full;
	logic            push;
	ifsf_pkg::cmd_t  push_cmd;
	logic            pop;
	logic            head_valid;
	ifsf_pkg::cmd_t  head;

	// Register file: a write request lands on the access cycle; pready stays high.
	assign pready  = 1'b1;
	assign wr_req  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ifsf_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value        <= ifsf_pkg::FLAG_RESET;
			cfg_q.escape_value      <= ifsf_pkg::ESCAPE_RESET;
			cfg_q.flag_substitute   <= ifsf_pkg::FLAG_SUB_RESET;
			cfg_q.escape_substitute <= ifsf_pkg::ESC_SUB_RESET;
			cfg_q.address_value     <= ifsf_pkg::ADDRESS_RESET;
		end else if (wr_req) begin
			unique case (reg_idx)
				ifsf_pkg::REG_FLAG:     cfg_q.flag_value        <= pwdata[7:0];
				ifsf_pkg::REG_ESCAPE:   cfg_q.escape_value      <= pwdata[7:0];
				ifsf_pkg::REG_FLAG_SUB: cfg_q.flag_substitute   <= pwdata[7:0];
				ifsf_pkg::REG_ESC_SUB:  cfg_q.escape_substitute <= pwdata[7:0];
				ifsf_pkg::REG_ADDRESS:  cfg_q.address_value     <= pwdata[7:0];
				default: ; // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ifsf_pkg::REG_FLAG:     rd_byte = cfg_q.flag_value;
			ifsf_pkg::REG_ESCAPE:   rd_byte = cfg_q.escape_value;
			ifsf_pkg::REG_FLAG_SUB: rd_byte = cfg_q.flag_substitute;
			ifsf_pkg::REG_ESC_SUB:  rd_byte = cfg_q.escape_substitute;
			ifsf_pkg::REG_ADDRESS:  rd_byte = cfg_q.address_value;
			default:                rd_byte = '0;
		endcase
	end

	assign prdata = {{(ifsf_pkg::PDATA_W - ifsf_pkg::BYTE_W){1'b0}}, rd_byte};

	// Front end: classify each packet byte and fold it into the frame check.
	ifsf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.data_byte      (s_axis_tdata),
		.first_of_frame (s_axis_tuser[0]),
		.last_of_frame  (s_axis_tlast),
		.no_stuff       (s_axis_tuser[1]),
		.sequence_bit   (s_axis_tuser[2]),
		.q_full         (q_full),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	// Queue: lets the front keep taking requests while the line side stalls, until it is full.
	ifsf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (head_valid),
		.head      (head)
	);

	// Back end: walk header, payload and trailer bytes into the output register.
	ifsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.run_last   (m_axis_tlast),
		.frame_end  (m_axis_tuser[0])
	);

endmodule
`default_nettype wire

/* tb/frame_checker.sv */
// Checker for the framer: predicts line bytes from accepted packet bytes and compares them.
`default_nettype none
module frame_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire                          pready,
	input  wire [ifsf_pkg::PADDR_W-1:0]  paddr,
	input  wire [ifsf_pkg::PDATA_W-1:0]  pwdata,
	input  wire                          s_axis_tvalid,
	input  wire                          s_axis_tready,
	input  wire [7:0]                    s_axis_tdata,  // [7:0] data_byte
	input  wire                          s_axis_tlast,  // last_of_frame
	input  wire [2:0]                    s_axis_tuser,  // [0] first_of_frame, [1] no_stuff,
	                                                    // [2] sequence_bit
	input  wire                          m_axis_tvalid,
	input  wire                          m_axis_tready,
	input  wire [7:0]                    m_axis_tdata,  // [7:0] out_byte
	input  wire                          m_axis_tlast,  // run_last
	input  wire [0:0]                    m_axis_tuser,  // [0] frame_end
	output int                           mismatches,
	output int                           bytes_owed
);

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       frame_end;
	} line_byte_t;

	line_byte_t       line_due[$];
	ifsf_pkg::cfg_t   regs;
	logic [7:0]       frame_check;
	logic             frame_open;
	int               fails;

	// Turn one packet byte into the line bytes it causes and queue them.
	task automatic expand_packet_byte(input logic [7:0] d, input logic opens, input logic closes,
			input logic raw, input logic seq);
		logic [7:0] burst [0:7];
		logic [7:0] control;
		line_byte_t entry;
		int n;
		n = 0;
		if (!opens && !frame_open)
			return;
		if (opens) begin
			control = {1'b0, seq, 6'b0};
			burst[0] = regs.flag_value;
			burst[1] = regs.address_value;
			burst[2] = control;
			burst[3] = regs.address_value ^ control;
			n = 4;
			frame_check = ifsf_pkg::CHECK_START;
			frame_open = 1'b1;
		end
		frame_check = frame_check ^ d;
		// flag comparison wins when flag and escape are equal
		if (!raw && d == regs.flag_value) begin
			burst[n] = regs.escape_value;
			burst[n+1] = regs.flag_substitute;
			n = n + 2;
		end else if (!raw && d == regs.escape_value) begin
			burst[n] = regs.escape_value;
			burst[n+1] = regs.escape_substitute;
			n = n + 2;
		end else begin
			burst[n] = d;
			n = n + 1;
		end
		if (closes) begin
			burst[n] = frame_check;
			burst[n+1] = regs.flag_value;
			n = n + 2;
			frame_open = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			entry.data = burst[i];
			entry.run_last = (i == n - 1);
			entry.frame_end = closes && (i == n - 1);
			line_due.push_back(entry);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		line_byte_t want;
		if (!arst_n) begin
			regs.flag_value = ifsf_pkg::FLAG_RESET;
			regs.escape_value = ifsf_pkg::ESCAPE_RESET;
			regs.flag_substitute = ifsf_pkg::FLAG_SUB_RESET;
			regs.escape_substitute = ifsf_pkg::ESC_SUB_RESET;
			regs.address_value = ifsf_pkg::ADDRESS_RESET;
			frame_check = ifsf_pkg::CHECK_START;
			frame_open = 1'b0;
			fails = 0;
			line_due.delete();
			mismatches <= 0;
			bytes_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ifsf_pkg::PADDR_W-1:2])
					ifsf_pkg::REG_FLAG:     regs.flag_value = pwdata[7:0];
					ifsf_pkg::REG_ESCAPE:   regs.escape_value = pwdata[7:0];
					ifsf_pkg::REG_FLAG_SUB: regs.flag_substitute = pwdata[7:0];
					ifsf_pkg::REG_ESC_SUB:  regs.escape_substitute = pwdata[7:0];
					ifsf_pkg::REG_ADDRESS:  regs.address_value = pwdata[7:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expand_packet_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tlast, s_axis_tuser[1],
					s_axis_tuser[2]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (line_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("checker: unexpected line byte %h last %b end %b",
							m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
				end else begin
					want = line_due.pop_front();
					if (want.data !== m_axis_tdata || want.run_last !== m_axis_tlast ||
							want.frame_end !== m_axis_tuser[0]) begin
						fails++;
						if (fails <= 10)
							$display("checker: line byte %h last %b end %b, want %h last %b end %b",
								m_axis_tdata, m_axis_tlast, m_axis_tuser[0],
								want.data, want.run_last, want.frame_end);
					end
				end
			end
			mismatches <= fails;
			bytes_owed <= line_due.size();
		end
	end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Top of the framer testbench: clock, reset, register writes, packet stimulus and verdict.
`default_nettype none
module testbench;

	localparam int LONG_HOLD = 300;  // cycles the line side refuses bytes during a choke

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [ifsf_pkg::PADDR_W-1:0] paddr = '0;
	logic [ifsf_pkg::PDATA_W-1:0] pwdata = '0;
	wire  [ifsf_pkg::PDATA_W-1:0] prdata;
	wire                          pready;
	logic                         s_axis_tvalid = 1'b0;
	wire                          s_axis_tready;
	logic [7:0]                   s_axis_tdata = '0;  // [7:0] data_byte
	logic                         s_axis_tlast = 1'b0;  // last_of_frame
	logic [2:0]                   s_axis_tuser = '0;  // [0] first_of_frame, [1] no_stuff,
	                                                  // [2] sequence_bit
	wire                          m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	wire  [7:0]                   m_axis_tdata;  // [7:0] out_byte
	wire                          m_axis_tlast;  // run_last
	wire  [0:0]                   m_axis_tuser;  // [0] frame_end

	int             mismatches;
	int             bytes_owed;
	ifsf_pkg::cfg_t line_cfg;     // our copy of the registers, used to aim data at special bytes
	logic           frame_live;   // a frame is open as far as the stimulus knows
	logic           no_gaps;      // sender runs back to back for the current frame
	int             items_sent;   // packet bytes that the framer acts on

	always #5 clk = ~clk;

	info_frame_stuffing_framer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	frame_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.bytes_owed    (bytes_owed)
	);

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// Packet byte aimed at the current special values or at 0x00/0xFF about half the time.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return line_cfg.flag_value;
			1: return line_cfg.escape_value;
			2: return line_cfg.flag_substitute;
			3: return line_cfg.escape_substitute;
			4: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Write one register: setup cycle, then access cycle; deassert and idle before returning
	// so that back to back writes never touch psel twice in one step.
	task automatic apb_write(input logic [ifsf_pkg::REG_IDX_W-1:0] idx, input logic [7:0] val);
		logic [31:0] junk;
		junk = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {junk[31:8], val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Load all five registers; poke an unmapped index first, which must change nothing.
	task automatic load_regs(input logic [7:0] f, input logic [7:0] e, input logic [7:0] fs,
			input logic [7:0] es, input logic [7:0] a);
		logic [ifsf_pkg::REG_IDX_W-1:0] beyond;
		beyond = ifsf_pkg::REG_ADDRESS + 3'($urandom_range(1, 3));
		apb_write(beyond, 8'($urandom_range(0, 255)));
		apb_write(ifsf_pkg::REG_FLAG, f);
		apb_write(ifsf_pkg::REG_ESCAPE, e);
		apb_write(ifsf_pkg::REG_FLAG_SUB, fs);
		apb_write(ifsf_pkg::REG_ESC_SUB, es);
		apb_write(ifsf_pkg::REG_ADDRESS, a);
		line_cfg.flag_value = f;
		line_cfg.escape_value = e;
		line_cfg.flag_substitute = fs;
		line_cfg.escape_substitute = es;
		line_cfg.address_value = a;
	endtask

	// Offer one packet byte after a random gap and hold it until the request is taken.
	// Called right after an edge; with no gap tvalid stays high and only the data moves.
	task automatic push_byte(input logic [7:0] d, input logic first, input logic last,
			input logic raw, input logic seq);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= last;
		s_axis_tuser <= {seq, raw, first};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// bytes outside a frame are dropped by the framer and do not count
		if (first || frame_live) begin
			items_sent++;
			frame_live = !last;
		end
	endtask

	// Drop tvalid, wait for every predicted line byte, then let the pipe drain.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_owed != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// One frame: a few raw header bytes, then payload, closed or abandoned.
	task automatic send_frame(input logic closed);
		int hdr, len, n;
		logic seq;
		seq = 1'($urandom_range(0, 1));
		hdr = $urandom_range(0, 3);
		len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(7, 20);
		n = hdr + len;
		if (n == 0)
			n = 1;
		no_gaps = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++)
			push_byte(pick_byte(), i == 0, closed && i == n - 1,
				(i < hdr) ? 1'b1 : ($urandom_range(0, 9) == 0), seq);
		no_gaps = 1'b0;
	endtask

	// Mostly well formed frames; the rest are stray bytes and abandoned frames.
	task automatic random_phase(input int count);
		int start;
		int r;
		start = items_sent;
		while (items_sent - start < count) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				push_byte(pick_byte(), 1'b0, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else if (r < 14)
				send_frame(1'b0);
			else
				send_frame(1'b1);
		end
	endtask

	// Line side: random stalls with quiet stretches, plus long chokes counted here.
	initial begin : line_sink
		int stall_left;
		int quiet_left;
		int beats;
		int chokes;
		logic ready_next;
		stall_left = 0;
		quiet_left = 0;
		beats = 0;
		chokes = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				beats++;
			if (chokes < 2 && beats >= (chokes == 0 ? 200 : 900)) begin
				// hold off long enough for the queue to fill and stall the sender
				chokes++;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (stall_left > 0) begin
					ready_next = 1'b0;
					stall_left--;
				end else begin
					ready_next = 1'b1;
					if (quiet_left > 0)
						quiet_left--;
					else if ($urandom_range(0, 149) == 0)
						quiet_left = $urandom_range(50, 150);
					else
						stall_left = pick_gap();
				end
				m_axis_tready <= ready_next;
			end
		end
	end

	initial begin : stimulus
		frame_live = 1'b0;
		no_gaps = 1'b0;
		items_sent = 0;
		line_cfg.flag_value = ifsf_pkg::FLAG_RESET;
		line_cfg.escape_value = ifsf_pkg::ESCAPE_RESET;
		line_cfg.flag_substitute = ifsf_pkg::FLAG_SUB_RESET;
		line_cfg.escape_substitute = ifsf_pkg::ESC_SUB_RESET;
		line_cfg.address_value = ifsf_pkg::ADDRESS_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on reset register values.
		push_byte(8'h55, 1'b0, 1'b0, 1'b0, 1'b0);  // byte while idle: dropped
		push_byte(8'h81, 1'b0, 1'b1, 1'b0, 1'b1);  // closing byte while idle: dropped
		push_byte(8'h00, 1'b1, 1'b0, 1'b1, 1'b0);  // open, raw header byte
		push_byte(8'hFF, 1'b0, 1'b0, 1'b1, 1'b0);
		push_byte(line_cfg.flag_value, 1'b0, 1'b0, 1'b0, 1'b0);    // stuffed flag
		push_byte(line_cfg.escape_value, 1'b0, 1'b0, 1'b0, 1'b1);  // stuffed escape
		push_byte(line_cfg.flag_value, 1'b0, 1'b0, 1'b1, 1'b0);    // raw flag passes
		push_byte(line_cfg.escape_value, 1'b0, 1'b0, 1'b1, 1'b0);  // raw escape passes
		push_byte(line_cfg.flag_substitute, 1'b0, 1'b0, 1'b0, 1'b0);
		push_byte(8'hA5, 1'b0, 1'b1, 1'b0, 1'b0);
		// one byte opens, is stuffed and closes: the longest burst
		push_byte(line_cfg.flag_value, 1'b1, 1'b1, 1'b0, 1'b1);
		// new frame while one is open: the first is abandoned
		push_byte(8'hAA, 1'b1, 1'b0, 1'b0, 1'b1);
		push_byte(8'h3C, 1'b0, 1'b0, 1'b0, 1'b0);
		push_byte(line_cfg.escape_value, 1'b1, 1'b0, 1'b0, 1'b0);
		push_byte(8'h01, 1'b0, 1'b1, 1'b0, 1'b1);
		// check byte equal to flag, then to escape: it must go out unstuffed
		push_byte(8'h70, 1'b1, 1'b0, 1'b1, 1'b0);
		push_byte(line_cfg.flag_value ^ 8'h70, 1'b0, 1'b1, 1'b0, 1'b0);
		push_byte(8'h70, 1'b1, 1'b0, 1'b0, 1'b1);
		push_byte(line_cfg.escape_value ^ 8'h70, 1'b0, 1'b1, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);  // idle again after close
		settle();

		// All registers zero: flag equals escape, so a zero byte takes the flag path.
		load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
		random_phase(80);
		settle();

		load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		random_phase(80);
		settle();

		begin : same_flag_escape
			logic [7:0] v;
			v = 8'($urandom_range(0, 255));
			load_regs(v, v, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end
		random_phase(80);
		settle();

		load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		random_phase(80);
		settle();

		load_regs(ifsf_pkg::FLAG_RESET, ifsf_pkg::ESCAPE_RESET, ifsf_pkg::FLAG_SUB_RESET,
			ifsf_pkg::ESC_SUB_RESET, ifsf_pkg::ADDRESS_RESET);
		random_phase(80);
		settle();

		if (mismatches == 0 && bytes_owed == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Bound the run well beyond the slowest correct one.
	initial begin : watchdog
		#15000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/ifsf_pkg.sv
rtl/core/ifsf_front.sv
rtl/core/ifsf_queue.sv
rtl/core/ifsf_back.sv
rtl/core/info_frame_stuffing_framer.sv
tb/frame_checker.sv
tb/testbench.sv
